// ----- sv/tem_pkg.sv -----
// Package for the tracking error monitor.
// Holds the sequencer state type, register indexes and fixed field widths.
// No dependencies.
package tem_pkg;

  localparam int unsigned ERR_W   = 32;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned ALPHA_W = 24;
  localparam int unsigned HALF_W  = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 24'd16777;
  localparam logic [ERR_W-1:0]   THR_RST   = 32'd6554;
  localparam logic [ERR_W-1:0]   LIMIT_RST = 32'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMA_ALPHA     = 2'd0,
    CFG_EMA_THRESHOLD = 2'd1,
    CFG_POOR_LIMIT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_MUL_LO,
    S_MUL_HI,
    S_EMA,
    S_EVAL,
    S_WAIT_DIV,
    S_OUT
  } state_t;

endpackage

// ----- sv/tracking_error_monitor.sv -----
// Tracking error monitor: absolute error, sliding window mean, exponential
// average and persistence alarm. Uses tem_pkg, tem_ram and tem_div.
// An accepted word passes through S_UPD, S_MUL_LO, S_MUL_HI, S_EMA, S_EVAL,
// S_WAIT_DIV and S_OUT; S_WAIT_DIV holds until the bit-serial mean divider is done.
// One word is worked on at a time; in_ready is low until the sequencer is back in S_IDLE.
// Reset (rst_n, synchronous): window empty, average and alarm state cleared,
// registers back to their defaults; window RAM contents are left as they are.
module tracking_error_monitor #(
  parameter int unsigned WINDOW = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tem_pkg::ERR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_estimate_pos,
  input  logic signed [31:0]            in_actual_pos,
  input  logic [31:0]                   in_timestamp_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_err_now,
  output logic [31:0]                   out_err_window_mean,
  output logic [31:0]                   out_err_smoothed,
  output logic                          out_degraded,
  output logic                          out_reset_request
);

  import tem_pkg::*;

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = ERR_W + CNT_W;
  localparam int unsigned PROD_W = HALF_W + ALPHA_W;

  state_t state_r, state_nxt;

  logic [ALPHA_W-1:0] alpha_r;
  logic [ERR_W-1:0]   thr_r;
  logic [ERR_W-1:0]   limit_r;

  logic [PTR_W-1:0]   wp_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic [ACC_W-1:0]   acc_r;
  logic               poor_r;
  logic [ERR_W-1:0]   poor_start_r;

  logic [ERR_W-1:0]   err_r;
  logic [ERR_W-1:0]   ts_r;
  logic [ACC_W-1:0]   d_r;
  logic               up_r;
  logic [PROD_W-1:0]  p_lo_r;
  logic [PROD_W-1:0]  p_hi_r;
  logic               degraded_r;
  logic               req_r;
  logic [ERR_W-1:0]   mean_r;

  logic               out_valid_r;
  logic [ERR_W-1:0]   out_err_r;
  logic [ERR_W-1:0]   out_mean_r;
  logic [ERR_W-1:0]   out_smooth_r;
  logic               out_degraded_r;
  logic               out_req_r;

  logic               in_acc;
  logic               out_load;
  logic [ERR_W-1:0]   err_in;
  logic [ERR_W-1:0]   old_err;
  logic               full;
  logic [ACC_W-1:0]   e_val;
  logic [63:0]        prod_sum;
  logic [ACC_W-1:0]   delta;
  logic               over;
  logic [ERR_W-1:0]   elapsed;
  logic               div_start;
  logic               div_valid;
  logic [SUM_W-1:0]   div_q;

  // configuration
  assign cfg_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      thr_r   <= THR_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EMA_ALPHA:     alpha_r <= cfg_data[ALPHA_W-1:0];
        CFG_EMA_THRESHOLD: thr_r   <= cfg_data;
        CFG_POOR_LIMIT:    limit_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // sequencer
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_UPD;
      S_UPD:      state_nxt = S_MUL_LO;
      S_MUL_LO:   state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_EMA;
      S_EMA:      state_nxt = S_EVAL;
      S_EVAL:     state_nxt = S_WAIT_DIV;
      S_WAIT_DIV: if (div_valid) state_nxt = S_OUT;
      S_OUT:      if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign div_start = (state_r == S_MUL_LO);

  // datapath
  assign err_in = (in_estimate_pos >= in_actual_pos) ?
                  ERR_W'(in_estimate_pos - in_actual_pos) :
                  ERR_W'(in_actual_pos - in_estimate_pos);

  assign full     = (cnt_r == CNT_W'(WINDOW));
  assign e_val    = {err_r, 8'd0};
  assign prod_sum = {p_hi_r, {HALF_W{1'b0}}} + 64'(p_lo_r);
  assign delta    = prod_sum[63:ALPHA_W];
  assign over     = acc_r > {thr_r, 8'd0};
  assign elapsed  = ts_r - poor_start_r;

  tem_ram #(
    .WIDTH (ERR_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (wp_r),
    .wdata (err_r),
    .re    (in_acc),
    .raddr (wp_r),
    .rdata (old_err)
  );

  tem_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (sum_r),
    .den      (cnt_r),
    .q_valid  (div_valid),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
      acc_r        <= '0;
      poor_r       <= 1'b0;
      poor_start_r <= '0;
    end else begin
      if (state_r == S_UPD) begin
        wp_r <= (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
        if (full) begin
          sum_r <= sum_r - SUM_W'(old_err) + SUM_W'(err_r);
        end else begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_r + SUM_W'(err_r);
        end
      end
      if (state_r == S_EMA) begin
        acc_r <= up_r ? acc_r + delta : acc_r - delta;
      end
      if (state_r == S_EVAL) begin
        if (over) begin
          if (!poor_r) begin
            poor_r       <= 1'b1;
            poor_start_r <= ts_r;
          end
        end else begin
          poor_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r <= err_in;
      ts_r  <= in_timestamp_ms;
    end
    if (state_r == S_UPD) begin
      up_r <= e_val >= acc_r;
      d_r  <= (e_val >= acc_r) ? e_val - acc_r : acc_r - e_val;
    end
    if (state_r == S_MUL_LO) begin
      p_lo_r <= d_r[HALF_W-1:0] * alpha_r;
    end
    if (state_r == S_MUL_HI) begin
      p_hi_r <= d_r[ACC_W-1:HALF_W] * alpha_r;
    end
    if (state_r == S_EVAL) begin
      degraded_r <= over;
      req_r      <= over && poor_r && (elapsed > limit_r);
    end
    if ((state_r == S_WAIT_DIV) && div_valid) begin
      mean_r <= div_q[ERR_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_err_r      <= err_r;
      out_mean_r     <= mean_r;
      out_smooth_r   <= acc_r[ACC_W-1:8];
      out_degraded_r <= degraded_r;
      out_req_r      <= req_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_err_now         = out_err_r;
  assign out_err_window_mean = out_mean_r;
  assign out_err_smoothed    = out_smooth_r;
  assign out_degraded        = out_degraded_r;
  assign out_reset_request   = out_req_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW))
    else $error("held count beyond window");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PTR_W'(WINDOW - 1))
    else $error("write pointer beyond window");

  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result word not presented after load");

  a_req_needs_degraded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_req_r || out_degraded_r))
    else $error("reset request without degraded");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> div_valid)
    else $error("mean not ready at output");

endmodule

// ----- sv/tem_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tem_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 100
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/tem_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Quotient stays valid until the next start. No package dependencies.
module tem_div #(
  parameter int unsigned NUM_W = 39,
  parameter int unsigned DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             q_valid,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              q_valid_r;
  logic [DEN_W:0]    shifted;
  logic              fits;

  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      q_valid_r <= 1'b0;
      step_r    <= '0;
    end else if (start) begin
      busy_r    <= 1'b1;
      q_valid_r <= 1'b0;
      step_r    <= STEP_W'(NUM_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r    <= 1'b0;
        q_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DEN_W'(shifted - {1'b0, den_r});
      end else begin
        rem_r <= shifted[DEN_W-1:0];
      end
      num_r <= {num_r[NUM_W-2:0], fits};
    end
  end

  assign q_valid  = q_valid_r;
  assign quotient = num_r;

endmodule
